[rtl/core/linear_probe_hash_set_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the linear probe hash set
// Concurrent checks clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_SET_TOP_DEFINES_SVH
`define LINEAR_PROBE_HASH_SET_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define LPHS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define LPHS_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define LPHS_ASSERT(lbl, prop, msg)
`define LPHS_NEVER(lbl, cond, msg)

`endif

`endif

[rtl/core/lphs_pkg.sv]
// ----------------------------------------------------------------------------
// lphs_pkg
// Shared sizes, codes and types of the linear probe hash set.
// ----------------------------------------------------------------------------
package lphs_pkg;

	// Slot count. It must be a power of two: the home slot is the low key bits.
	localparam int TABLE_SLOTS = 256;
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);
	localparam int CNT_W       = SLOT_W + 1;
	localparam int LIVE_W      = $clog2(TABLE_SLOTS + 1);
	localparam int FILL_W      = 9;
	localparam int CMP_W       = (LIVE_W > FILL_W) ? LIVE_W : FILL_W;
	localparam int KEY_W       = 64;
	localparam int ENTRY_W     = KEY_W + 2;

	localparam logic [FILL_W-1:0] MAX_FILL_RST = FILL_W'(192);

	// Request kinds.
	localparam logic [1:0] REQ_LOOKUP = 2'd0;
	localparam logic [1:0] REQ_INSERT = 2'd1;
	localparam logic [1:0] REQ_DELETE = 2'd2;

	// Result status codes.
	localparam logic [1:0] RS_OK     = 2'd0;
	localparam logic [1:0] RS_FULL   = 2'd1;
	localparam logic [1:0] RS_ABSENT = 2'd2;
	localparam logic [1:0] RS_DUP    = 2'd3;

	typedef enum logic [1:0] {
		SS_EMPTY = 2'd0,
		SS_USED  = 2'd1,
		SS_TOMB  = 2'd2
	} slot_st_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_DONE
	} lphs_state_t;

endpackage

[rtl/core/lphs_ram.sv]
// ----------------------------------------------------------------------------
// lphs_ram
// Single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module lphs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/linear_probe_hash_set_top.sv]
// ----------------------------------------------------------------------------
// linear_probe_hash_set_top
// Open-addressing set of 64-bit keys with linear probing and tombstones.
// ----------------------------------------------------------------------------
// One request is handled at a time. A probe walk visits from 1 up to
// TABLE_SLOTS slots: the home slot is read in the accepting cycle, the
// walk then checks one slot of the entry memory per cycle through its
// single read port, and the DONE state hands the result into the output
// register before the block returns to idle for the next request. A result
// that still waits to be taken holds the finished walk until it leaves. A
// finished result sits in an output register, so the next request is
// accepted while the previous result still waits to be taken. After reset
// the block marks every slot empty and accepts no request until it is
// done; writes to max_fill are taken at any time. Each memory entry holds
// a two-bit slot state (empty, used, tombstone) above the 64-bit key.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_set_top_defines.svh"

module linear_probe_hash_set_top
	import lphs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// Request stream.
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [63:0]       s_tdata,   // [63:0] key
	input  logic [1:0]        s_tuser,   // [1:0] req_type
	// Result stream.
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata,   // [0] found, [8:1] slot, [10:9] status,
	                                     // [19:11] live_count, [23:20] zero
	// Fill limit register.
	input  logic              max_fill_we,
	input  logic [FILL_W-1:0] max_fill_wdata
);

	lphs_state_t state_q, state_nxt;

	logic [FILL_W-1:0] max_fill_q;
	logic [CNT_W-1:0]  clr_q;
	logic [SLOT_W-1:0] idx_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              tomb_seen_q;
	logic [SLOT_W-1:0] tomb_at_q;
	logic [KEY_W-1:0]  key_q;
	logic [1:0]        req_q;
	logic [LIVE_W-1:0] live_q;
	logic              res_found_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [1:0]        res_status_q;
	logic              m_tvalid_q;
	logic [23:0]       m_tdata_q;

	logic               ram_we;
	logic [SLOT_W-1:0]  ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [SLOT_W-1:0]  ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	logic              in_acc;
	logic              out_free;
	logic              clr_last;
	logic [SLOT_W-1:0] idx_nxt;

	// Walk evaluation of the slot just read.
	slot_st_t          rd_st;
	logic              is_empty;
	logic              is_hit;
	logic              is_tomb;
	logic              walk_last;
	logic              walk_end;
	logic              tomb_seen_nxt;
	logic [SLOT_W-1:0] tomb_at_nxt;
	logic              has_free;
	logic              over_limit;

	// Outcome of the finished walk.
	logic              fin_found;
	logic [SLOT_W-1:0] fin_slot;
	logic [1:0]        fin_status;
	logic              fin_write;
	slot_st_t          fin_wr_st;
	logic [SLOT_W-1:0] fin_wr_slot;
	logic [LIVE_W-1:0] fin_live;

	lphs_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_SLOTS)
	) u_entries (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign clr_last = (clr_q == CNT_W'(TABLE_SLOTS - 1));
	assign idx_nxt  = (idx_q == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : idx_q + 1'b1;

	// The read data belongs to slot idx_q while walking. A state code that is
	// neither empty nor used is passed over like a tombstone.
	always_comb begin
		rd_st         = slot_st_t'(ram_rdata[ENTRY_W-1 -: 2]);
		is_empty      = (rd_st == SS_EMPTY);
		is_hit        = (rd_st == SS_USED) && (ram_rdata[KEY_W-1:0] == key_q);
		is_tomb       = !is_empty && (rd_st != SS_USED);
		walk_last     = (cnt_q == CNT_W'(TABLE_SLOTS - 1));
		walk_end      = is_empty || is_hit || walk_last;
		tomb_seen_nxt = tomb_seen_q || is_tomb;
		tomb_at_nxt   = tomb_seen_q ? tomb_at_q : idx_q;
		// An empty slot offers the first tombstone seen, or itself.
		has_free      = is_empty || tomb_seen_nxt;
		over_limit    = CMP_W'(live_q) >= CMP_W'(max_fill_q);
	end

	always_comb begin
		fin_found   = is_hit;
		fin_slot    = '0;
		fin_status  = RS_OK;
		fin_write   = 1'b0;
		fin_wr_st   = SS_USED;
		fin_wr_slot = tomb_at_nxt;
		fin_live    = live_q;
		case (req_q)
			REQ_INSERT: begin
				if (is_hit) begin
					fin_slot   = idx_q;
					fin_status = RS_DUP;
				end else if (over_limit || !has_free) begin
					fin_status = RS_FULL;
				end else begin
					fin_write = 1'b1;
					fin_slot  = tomb_at_nxt;
					fin_live  = live_q + 1'b1;
				end
			end
			REQ_DELETE: begin
				if (is_hit) begin
					fin_write   = 1'b1;
					fin_wr_st   = SS_TOMB;
					fin_wr_slot = idx_q;
					fin_slot    = idx_q;
					if (live_q != '0) begin
						fin_live = live_q - 1'b1;
					end
				end else begin
					fin_status = RS_ABSENT;
				end
			end
			default: begin
				// Lookup; the unused selector behaves the same.
				if (is_hit) begin
					fin_slot = idx_q;
				end
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = ST_WALK;
				end
			end
			ST_WALK: begin
				if (walk_end) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// State machine outputs: handshake and memory control.
	always_comb begin
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = fin_wr_slot;
		ram_wdata = {fin_wr_st, key_q};
		ram_raddr = idx_nxt;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q[SLOT_W-1:0];
				ram_wdata = {SS_EMPTY, {KEY_W{1'b0}}};
			end
			ST_IDLE: begin
				s_tready  = 1'b1;
				ram_raddr = s_tdata[SLOT_W-1:0];
			end
			ST_WALK: begin
				ram_we = walk_end && fin_write;
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			max_fill_q <= MAX_FILL_RST;
			live_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (max_fill_we) begin
				max_fill_q <= max_fill_wdata;
			end
			if (state_q == ST_WALK && walk_end) begin
				live_q <= fin_live;
			end
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Walk and result payload.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			key_q       <= s_tdata;
			req_q       <= s_tuser;
			idx_q       <= s_tdata[SLOT_W-1:0];
			cnt_q       <= '0;
			tomb_seen_q <= 1'b0;
			tomb_at_q   <= '0;
		end else if (state_q == ST_WALK) begin
			idx_q       <= idx_nxt;
			cnt_q       <= cnt_q + 1'b1;
			tomb_seen_q <= tomb_seen_nxt;
			tomb_at_q   <= tomb_at_nxt;
			if (walk_end) begin
				res_found_q  <= fin_found;
				res_slot_q   <= fin_slot;
				res_status_q <= fin_status;
			end
		end
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= {4'b0, 9'(live_q), res_status_q, 8'(res_slot_q), res_found_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`LPHS_NEVER(a_live_bound, live_q > LIVE_W'(TABLE_SLOTS), "live count above slot count")
	`LPHS_NEVER(a_write_window, ram_we && state_q != ST_CLEAR && state_q != ST_WALK, "stray memory write")
	`LPHS_ASSERT(a_insert_count, (state_q == ST_WALK && walk_end && fin_write && req_q == REQ_INSERT) |=> (live_q == $past(live_q) + 1'b1), "insert did not add one live key")
	`LPHS_ASSERT(a_done_path, (state_q == ST_DONE && out_free) |=> (m_tvalid && state_q == ST_IDLE), "result not handed to output")

endmodule

[test/hash_set_checker.sv]
// ----------------------------------------------------------------------------
// Hash set result checker
// Keeps a shadow copy of the probed set, predicts the result of every
// accepted request and compares the result stream against it field by field.
// ----------------------------------------------------------------------------
module hash_set_checker
	import lphs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [63:0]       s_tdata,   // [63:0] key
	input  logic [1:0]        s_tuser,   // [1:0] req_type
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [23:0]       m_tdata,   // [0] found, [8:1] slot, [10:9] status,
	                                     // [19:11] live_count, [23:20] zero
	input  logic              max_fill_we,
	input  logic [FILL_W-1:0] max_fill_wdata,
	output int                errors,
	output int                pending,
	output int                n_checked,
	output int                n_hits,
	output int                n_dups,
	output int                n_refused,
	output int                n_absent
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
		logic [1:0]        status;
		logic [LIVE_W-1:0] live;
	} set_outcome_t;

	logic [KEY_W-1:0]  shadow_keys  [TABLE_SLOTS];
	slot_st_t          shadow_state [TABLE_SLOTS];
	int unsigned       shadow_live;
	logic [FILL_W-1:0] fill_limit;
	set_outcome_t      expected_outcomes [$];

	// Walks the probe chain of the key, applies the request to the shadow set
	// and returns the result the block should give for it.
	function automatic set_outcome_t apply_request(logic [1:0] kind, logic [KEY_W-1:0] k);
		set_outcome_t res;
		int unsigned  idx;
		int unsigned  hit_at;
		int unsigned  free_at;
		int unsigned  tomb_at;
		int unsigned  n;
		bit           hit;
		bit           tomb_seen;
		bit           has_free;
		bit           stop;
		idx       = 32'(k % TABLE_SLOTS);
		hit       = 1'b0;
		tomb_seen = 1'b0;
		has_free  = 1'b0;
		stop      = 1'b0;
		hit_at    = 0;
		free_at   = 0;
		tomb_at   = 0;
		for (n = 0; n < TABLE_SLOTS && !stop; n++) begin
			case (shadow_state[idx])
			SS_EMPTY: begin
				has_free = 1'b1;
				free_at  = tomb_seen ? tomb_at : idx;
				stop     = 1'b1;
			end
			SS_USED: begin
				if (shadow_keys[idx] == k) begin
					hit    = 1'b1;
					hit_at = idx;
					stop   = 1'b1;
				end
			end
			default: begin
				if (!tomb_seen) begin
					tomb_seen = 1'b1;
					tomb_at   = idx;
				end
			end
			endcase
			if (!stop)
				idx = (idx + 1) % TABLE_SLOTS;
		end
		// A full circle with no empty slot can still place a key on a tombstone.
		if (!hit && !has_free && tomb_seen) begin
			has_free = 1'b1;
			free_at  = tomb_at;
		end

		res       = '0;
		res.found = hit;
		case (kind)
		REQ_INSERT: begin
			if (hit) begin
				res.slot   = SLOT_W'(hit_at);
				res.status = RS_DUP;
			end else if (shadow_live >= fill_limit || !has_free) begin
				res.status = RS_FULL;
			end else begin
				shadow_keys[free_at]  = k;
				shadow_state[free_at] = SS_USED;
				shadow_live++;
				res.slot = SLOT_W'(free_at);
			end
		end
		REQ_DELETE: begin
			if (hit) begin
				shadow_state[hit_at] = SS_TOMB;
				if (shadow_live > 0)
					shadow_live--;
				res.slot = SLOT_W'(hit_at);
			end else begin
				res.status = RS_ABSENT;
			end
		end
		default: begin
			if (hit)
				res.slot = SLOT_W'(hit_at);
		end
		endcase
		res.live = LIVE_W'(shadow_live);
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] result %0d: %s", $time, n_checked, msg);
		errors++;
	endtask

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want)
			report_mismatch($sformatf("%s expected %0d, got %0d", name, want, got));
	endtask

	always @(posedge clk or negedge arst_n) begin
		set_outcome_t want;
		if (!arst_n) begin
			foreach (shadow_state[i])
				shadow_state[i] = SS_EMPTY;
			shadow_live = 0;
			fill_limit  = MAX_FILL_RST;
			expected_outcomes.delete();
			pending = 0;
		end else begin
			if (max_fill_we)
				fill_limit = max_fill_wdata;
			if (s_tvalid && s_tready)
				expected_outcomes.push_back(apply_request(s_tuser, s_tdata));
			if (m_tvalid && m_tready) begin
				if (expected_outcomes.size() == 0) begin
					report_mismatch($sformatf("unexpected result 0x%06h", m_tdata));
				end else begin
					want = expected_outcomes.pop_front();
					check_field("found", 16'(want.found), 16'(m_tdata[0]));
					check_field("slot", 16'(want.slot), 16'(m_tdata[8:1]));
					check_field("status", 16'(want.status), 16'(m_tdata[10:9]));
					check_field("live_count", 16'(want.live), 16'(m_tdata[19:11]));
					if (want.found)
						n_hits++;
					if (want.status == RS_DUP)
						n_dups++;
					if (want.status == RS_FULL)
						n_refused++;
					if (want.status == RS_ABSENT)
						n_absent++;
				end
				n_checked++;
			end
			pending = expected_outcomes.size();
		end
	end

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// Linear probe hash set testbench
// Drives lookup, insert and delete requests through a directed opening,
// clustered random phases under several fill limits and a full-table phase,
// while the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lphs_pkg::*;

	// The request selector has one spare code that the block treats as a lookup.
	localparam logic [1:0] REQ_SPARE = 2'd3;

	// The slowest correct request walks every slot, and the receiver may stall
	// on top of that, so the watchdog sits far above any expected run length.
	localparam int unsigned CYCLE_LIMIT = 3_000_000;
	localparam int          N_PHASES    = 8;
	localparam int          PHASE_ITEMS = 220;

	localparam logic [63:0] K_ZERO     = 64'h0000_0000_0000_0000;
	localparam logic [63:0] K_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] K_WRAP_A   = 64'h0000_0000_0000_01FF;
	localparam logic [63:0] K_WRAP_B   = 64'h8000_0000_0000_02FF;
	localparam logic [63:0] K_TOP_BIT  = 64'h8000_0000_0000_0000;
	localparam logic [63:0] K_HOME0    = 64'h0000_0000_0000_0100;
	localparam logic [63:0] K_FIVES    = 64'h5555_5555_5555_5555;
	localparam logic [63:0] K_TENS     = 64'hAAAA_AAAA_AAAA_AAAA;

	// Fill limit and home-slot cluster width of each random phase. The limits
	// include both ends of the legal range and both ends of the register.
	logic [FILL_W-1:0] phase_fill   [N_PHASES] = '{9'd256, 9'd1, 9'd48, 9'd0,
	                                              9'd511, 9'd96, 9'd20, 9'd192};
	int                phase_window [N_PHASES] = '{8, 64, 16, 32, 4, 128, 24, 48};

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_MOSTLY,
		RX_SPARSE,
		RX_PERIODIC
	} rx_pattern_t;

	logic              clk            = 1'b0;
	logic              arst_n         = 1'b0;
	logic              s_tvalid       = 1'b0;
	logic              s_tready;
	logic [63:0]       s_tdata        = '0;   // [63:0] key
	logic [1:0]        s_tuser        = '0;   // [1:0] req_type
	logic              m_tvalid;
	logic              m_tready       = 1'b0;
	logic [23:0]       m_tdata;               // [0] found, [8:1] slot, [10:9] status,
	                                          // [19:11] live_count, [23:20] zero
	logic              max_fill_we    = 1'b0;
	logic [FILL_W-1:0] max_fill_wdata = '0;

	int errors;
	int pending;
	int n_checked;
	int n_hits;
	int n_dups;
	int n_refused;
	int n_absent;

	int unsigned cycle_count = 0;
	int unsigned n_sent      = 0;
	int unsigned burst_left  = 0;
	bit          steady      = 1'b0;
	rx_pattern_t rx_pattern  = RX_OPEN;
	int unsigned rx_left     = 0;
	logic [63:0] fill_keys [$];

	always #6 clk = ~clk;

	linear_probe_hash_set_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.max_fill_we    (max_fill_we),
		.max_fill_wdata (max_fill_wdata)
	);

	hash_set_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.max_fill_we    (max_fill_we),
		.max_fill_wdata (max_fill_wdata),
		.errors         (errors),
		.pending        (pending),
		.n_checked      (n_checked),
		.n_hits         (n_hits),
		.n_dups         (n_dups),
		.n_refused      (n_refused),
		.n_absent       (n_absent)
	);

	// Watchdog. A hung handshake or a result that never comes ends up here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still outstanding.",
				cycle_count, pending);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// The result side picks a backpressure pattern, holds it for a random
	// stretch and then picks again. Open stretches let results drain at full
	// rate, while the sparse and periodic ones keep the output register full
	// so that new requests are accepted behind a waiting result.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
			rx_left    <= $urandom_range(16, 200);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_pattern)
		RX_OPEN:     m_tready <= 1'b1;
		RX_MOSTLY:   m_tready <= ($urandom_range(0, 3) != 0);
		RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
		default:     m_tready <= ((rx_left % 9) < 4);
		endcase
	end

	// The request side sends in bursts of random length. Between bursts it
	// drops tvalid for a short or, now and then, a long gap. When steady is
	// set, requests follow each other back to back.
	task automatic pace();
		int unsigned gap;
		if (steady)
			return;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(1, 24);
		gap = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 6);
		s_tvalid <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	// Presents one request and holds it until the block takes it. This is
	// entered and left at a rising edge; unless pace() opens a gap, tvalid
	// stays high on return so that the next request can follow without a bubble.
	task automatic send_req(logic [1:0] kind, logic [63:0] k);
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= k;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		n_sent++;
		pace();
	endtask

	// Stops sending and waits until every result has been taken. The count is
	// sampled at the falling edge, where all updates of the rising edge are
	// settled; the task returns on a rising edge.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	// The fill limit is only changed with the block idle.
	task automatic set_fill_limit(logic [FILL_W-1:0] limit);
		wait_idle();
		max_fill_we    <= 1'b1;
		max_fill_wdata <= limit;
		@(posedge clk);
		max_fill_we    <= 1'b0;
	endtask

	// Random traffic around a small pool of keys whose home slots fall in a
	// window of the table. The narrow windows build long clusters, wraps and
	// tombstone chains; the pool makes hits, duplicates and real deletes common.
	// One request in ten uses a fresh random key instead.
	task automatic run_mixed(int n_items, int window);
		logic [63:0] pool [$];
		logic [63:0] k;
		logic [7:0]  base;
		int          roll;
		base = 8'($urandom);
		repeat (40) begin
			k = {$urandom, $urandom};
			if ($urandom_range(0, 3) == 0)
				k[63:8] = 56'($urandom_range(0, 3));
			k[7:0] = 8'(base + $urandom_range(0, window - 1));
			pool.push_back(k);
		end
		repeat (n_items) begin
			if ($urandom_range(0, 9) == 0)
				k = {$urandom, $urandom};
			else
				k = pool[$urandom_range(0, pool.size() - 1)];
			roll = $urandom_range(0, 99);
			if (roll < 40)
				send_req(REQ_INSERT, k);
			else if (roll < 65)
				send_req(REQ_LOOKUP, k);
			else if (roll < 70)
				send_req(REQ_SPARE, k);
			else
				send_req(REQ_DELETE, k);
		end
	endtask

	// Fills every slot with the limit out of the way, so that the last
	// inserts find no room at all. Then, at the exact slot count as limit,
	// tries more inserts, walks the whole table for absent keys, punches
	// tombstones into the full table and reuses them.
	task automatic run_full_table();
		logic [63:0] k;
		set_fill_limit(9'd511);
		repeat (280) begin
			k = {$urandom, $urandom};
			fill_keys.push_back(k);
			send_req(REQ_INSERT, k);
			if ($urandom_range(0, 7) == 0)
				send_req(REQ_LOOKUP, fill_keys[$urandom_range(0, fill_keys.size() - 1)]);
		end
		set_fill_limit(9'd256);
		repeat (2) send_req(REQ_INSERT, {$urandom, $urandom});
		repeat (2) send_req(REQ_LOOKUP, {$urandom, $urandom});
		repeat (24)
			send_req(REQ_DELETE, fill_keys[$urandom_range(0, fill_keys.size() - 1)]);
		repeat (24) begin
			send_req(REQ_INSERT, {$urandom, $urandom});
			send_req(REQ_LOOKUP, fill_keys[$urandom_range(0, fill_keys.size() - 1)]);
			send_req(REQ_DELETE, {$urandom, $urandom});
		end
	endtask

	initial begin
		// Reset is held low from the start and released on a rising edge. The
		// block then clears its table before it raises s_tready, which the
		// first request simply waits out.
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening with the fill limit at its reset value. Key zero
		// hits at slot 0, the all-ones key sits in the last slot and a second
		// key homed there wraps around to the front of the table.
		send_req(REQ_LOOKUP, K_ZERO);        // empty table, nothing found
		send_req(REQ_DELETE, K_ZERO);        // delete of an absent key
		send_req(REQ_INSERT, K_ZERO);        // lands in slot 0
		send_req(REQ_SPARE, K_ZERO);         // spare code looks up, hit at slot 0
		send_req(REQ_INSERT, K_ZERO);        // duplicate insert
		send_req(REQ_INSERT, K_ONES);        // last slot
		send_req(REQ_INSERT, K_WRAP_A);      // homed at the last slot, wraps past slot 0
		send_req(REQ_LOOKUP, K_WRAP_A);
		send_req(REQ_DELETE, K_ZERO);        // leaves a tombstone in slot 0
		send_req(REQ_LOOKUP, K_WRAP_A);      // the walk must pass the tombstone
		send_req(REQ_DELETE, K_ZERO);        // a tombstone is not a live key
		send_req(REQ_INSERT, K_WRAP_B);      // reuses the tombstone in slot 0
		send_req(REQ_INSERT, K_TOP_BIT);     // homed at slot 0, goes past the cluster
		send_req(REQ_LOOKUP, K_HOME0);       // absent key, walk ends at an empty slot
		send_req(REQ_DELETE, K_WRAP_A);
		send_req(REQ_LOOKUP, K_TOP_BIT);

		// Three keys are live now. With the limit at three, a new key is
		// refused while a duplicate is still reported as one.
		set_fill_limit(9'd3);
		send_req(REQ_INSERT, K_FIVES);
		send_req(REQ_INSERT, K_WRAP_B);

		// A limit of zero refuses every insert, even with the count lowered.
		set_fill_limit(9'd0);
		send_req(REQ_DELETE, K_ONES);
		send_req(REQ_INSERT, K_TENS);

		// Random phases, each under its own limit and with the block drained
		// before the limit changes. Every third phase sends without gaps.
		for (int p = 0; p < N_PHASES; p++) begin
			set_fill_limit(phase_fill[p]);
			steady = (p % 3 == 1);
			run_mixed(PHASE_ITEMS, phase_window[p]);
		end
		steady = 1'b0;

		run_full_table();

		// Drain, then give a walk over the whole table time to show up as a
		// stray result before the verdict.
		wait_idle();
		repeat (TABLE_SLOTS + 8) @(posedge clk);

		$display("Sent %0d requests over clustered random phases and a full table.", n_sent);
		$display("Checked %0d results: %0d hits, %0d duplicates, %0d refused, %0d absent deletes.",
			n_checked, n_hits, n_dups, n_refused, n_absent);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches.", errors);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
